// ----- rtl/fdl_pkg.sv -----
// Shared widths, sample type and pipeline control struct for the fractional delay line.
// No dependencies; imported by fdl_tap and fractional_delay_line_top.
`default_nettype none

package fdl_pkg;

  localparam int DEPTH     = 65536;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int POS_W     = ADDR_W + 1;
  localparam int SAMPLE_W  = 24;
  localparam int BUF_LEN_W = 17;
  localparam int DELAY_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int CMP_W     = (BUF_LEN_W > POS_W) ? BUF_LEN_W : POS_W;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int PROD_W    = DIFF_W + FRAC_W + 1;

  localparam int BUF_LEN_RESET = 65536;

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic valid;
    logic fwd_a;
    logic fwd_b;
    logic hit_a;
    logic hit_b;
  } fdl_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/fdl_tap.sv -----
// Tap arithmetic: operand select, linear interpolation multiply and output register.
// Depends on fdl_pkg.
`default_nettype none

module fdl_tap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  fdl_pkg::fdl_ctl_t             ctl,
  input  fdl_pkg::sample_t              rdata_a,
  input  fdl_pkg::sample_t              rdata_b,
  input  fdl_pkg::sample_t              fwd_sample,
  input  logic [fdl_pkg::FRAC_W-1:0]    delay_frac,
  input  logic                          interp_mode,
  output logic                          tap_valid,
  output fdl_pkg::sample_t              tap_out
);
  import fdl_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) <<< (FRAC_W - 1);

  sample_t                   a;
  sample_t                   b;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  step;
  sample_t                   tap_next;

  logic                      s2_valid;
  sample_t                   s2_a;
  logic signed [PROD_W-1:0]  s2_prod;

  // Take the same-cycle write, else stored data, else zero for never-written slots.
  always_comb begin
    a = ctl.fwd_a ? fwd_sample : (ctl.hit_a ? rdata_a : '0);
    b = ctl.fwd_b ? fwd_sample : (ctl.hit_b ? rdata_b : '0);
  end

  assign diff = DIFF_W'(b) - DIFF_W'(a);
  assign prod = PROD_W'($signed({1'b0, delay_frac})) * PROD_W'(diff);

  // Round half up, then floor by arithmetic shift; the blend stays between a and b.
  assign step     = (s2_prod + ROUND) >>> FRAC_W;
  assign tap_next = interp_mode ? sample_t'(s2_a + $signed(step[SAMPLE_W-1:0])) : s2_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      tap_valid <= 1'b0;
    end else if (advance) begin
      s2_valid  <= ctl.valid;
      tap_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_a    <= a;
      s2_prod <= prod;
      tap_out <= tap_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fractional_delay_line_top.sv -----
// Fractional delay line top level: APB registers, circular sample buffer and address logic.
// Depends on fdl_pkg and fdl_tap.
//
// One sample in, one tap out, at a sustained rate of one transaction per clock while no
// tap waits on tap_ready; results pass the read, interpolation and output registers.
// The rate is set by the sample buffer: a single RAM with one write port and two
// registered read ports, so every sample is stored and both taps (read position and
// the slot after it) are fetched in the cycle the sample is accepted. A read that hits
// the slot being written that cycle is forwarded from the incoming sample. The buffer
// needs no clearing pass after reset: writes always fill a prefix of the buffer, so a
// fill count marks which slots hold data and any slot beyond it reads as zero. Write
// the registers only while the line is empty; derived limits (clamped length,
// saturated delay) are updated in the same cycle as the register write.
`default_nettype none

module fractional_delay_line_top (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // sample input
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in,
  // tap output
  output logic                        tap_valid,
  input  logic                        tap_ready,
  output logic signed [fdl_pkg::SAMPLE_W-1:0] tap_out
);
  import fdl_pkg::*;

  localparam logic [1:0] REG_BUFFER_LENGTH = 2'd0;
  localparam logic [1:0] REG_DELAY_WHOLE   = 2'd1;
  localparam logic [1:0] REG_DELAY_FRAC    = 2'd2;
  localparam logic [1:0] REG_INTERP_MODE   = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]           reg_index;
  logic                 cfg_we;

  logic [BUF_LEN_W-1:0] buffer_length, buffer_length_next;
  logic [DELAY_W-1:0]   delay_whole, delay_whole_next;
  logic [FRAC_W-1:0]    delay_frac, delay_frac_next;
  logic                 interp_mode, interp_mode_next;

  // Derived limits, kept in step with the raw registers.
  logic [POS_W-1:0]     len_m1, len_m1_next;
  logic [POS_W-1:0]     delay_eff, delay_eff_next;
  logic [POS_W-1:0]     len_sub_delay, len_sub_delay_next;

  logic [CMP_W-1:0]     len_w;
  logic [CMP_W-1:0]     dly_w;

  assign reg_index = paddr[3:2];
  assign cfg_we    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    buffer_length_next = buffer_length;
    delay_whole_next   = delay_whole;
    delay_frac_next    = delay_frac;
    interp_mode_next   = interp_mode;
    if (rst) begin
      buffer_length_next = BUF_LEN_W'(BUF_LEN_RESET);
      delay_whole_next   = '0;
      delay_frac_next    = '0;
      interp_mode_next   = 1'b0;
    end else if (cfg_we) begin
      case (reg_index)
        REG_BUFFER_LENGTH: buffer_length_next = pwdata[BUF_LEN_W-1:0];
        REG_DELAY_WHOLE:   delay_whole_next   = pwdata[DELAY_W-1:0];
        REG_DELAY_FRAC:    delay_frac_next    = pwdata[FRAC_W-1:0];
        REG_INTERP_MODE:   interp_mode_next   = pwdata[0];
        default: ;
      endcase
    end

    // Clamp the length to the buffer, then saturate the delay below it.
    len_w = CMP_W'(buffer_length_next);
    if (len_w < CMP_W'(2)) begin
      len_w = CMP_W'(2);
    end else if (len_w > CMP_W'(DEPTH)) begin
      len_w = CMP_W'(DEPTH);
    end
    dly_w = CMP_W'(delay_whole_next);
    if (dly_w >= len_w) begin
      dly_w = len_w - CMP_W'(1);
    end

    len_m1_next        = POS_W'(len_w - CMP_W'(1));
    delay_eff_next     = POS_W'(dly_w);
    len_sub_delay_next = POS_W'(len_w - dly_w);
  end

  always_ff @(posedge clk) begin
    buffer_length <= buffer_length_next;
    delay_whole   <= delay_whole_next;
    delay_frac    <= delay_frac_next;
    interp_mode   <= interp_mode_next;
    len_m1        <= len_m1_next;
    delay_eff     <= delay_eff_next;
    len_sub_delay <= len_sub_delay_next;
  end

  always_comb begin
    case (reg_index)
      REG_BUFFER_LENGTH: prdata = 32'(buffer_length);
      REG_DELAY_WHOLE:   prdata = 32'(delay_whole);
      REG_DELAY_FRAC:    prdata = 32'(delay_frac);
      REG_INTERP_MODE:   prdata = 32'(interp_mode);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Address generation
  // ---------------------------------------------------------------------------
  logic             advance;
  logic             accept;
  addr_t            write_pos;
  logic [POS_W-1:0] fill;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] rd_p;
  logic [POS_W-1:0] rd1_p;
  addr_t            rd;
  addr_t            rd1;

  // Hold the whole pipeline while a finished tap waits to be taken.
  assign advance      = !tap_valid || tap_ready;
  assign sample_ready = advance;
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    // Advance the write position, wrapping at the length (also when it lies beyond it).
    if (POS_W'(write_pos) >= len_m1) begin
      pos_next = '0;
    end else begin
      pos_next = POS_W'(write_pos) + POS_W'(1);
    end

    // Step back by the delay, wrapping below zero.
    if (pos_next >= delay_eff) begin
      rd_p = pos_next - delay_eff;
    end else begin
      rd_p = pos_next + len_sub_delay;
    end

    rd1_p = rd_p + POS_W'(1);
    rd    = rd_p[ADDR_W-1:0];
    rd1   = (rd_p == len_m1) ? '0 : rd1_p[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      fill      <= '0;
    end else if (accept) begin
      write_pos <= pos_next[ADDR_W-1:0];
      if (POS_W'(write_pos) == fill) begin
        fill <= fill + POS_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample buffer: one write port, two registered read ports
  // ---------------------------------------------------------------------------
  sample_t  sample_store [DEPTH];
  sample_t  rdata_a;
  sample_t  rdata_b;
  sample_t  fwd_sample;
  fdl_ctl_t s1_ctl;

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_store[write_pos] <= sample_in;
      rdata_a                 <= sample_store[rd];
      rdata_b                 <= sample_store[rd1];
      fwd_sample              <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (advance) begin
      s1_ctl.valid <= accept;
      s1_ctl.fwd_a <= (rd == write_pos);
      s1_ctl.fwd_b <= (rd1 == write_pos);
      s1_ctl.hit_a <= (POS_W'(rd) < fill);
      s1_ctl.hit_b <= (POS_W'(rd1) < fill);
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation and output register
  // ---------------------------------------------------------------------------
  fdl_tap u_tap (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .ctl         (s1_ctl),
    .rdata_a     (rdata_a),
    .rdata_b     (rdata_b),
    .fwd_sample  (fwd_sample),
    .delay_frac  (delay_frac),
    .interp_mode (interp_mode),
    .tap_valid   (tap_valid),
    .tap_out     (tap_out)
  );

endmodule

`default_nettype wire
